### rtl/mcc_pkg.sv
// Shared types and constants for the mixture component CDF block.
package mcc_pkg;

    localparam int NUM_COMP = 10;
    localparam int COMP_W   = 4;
    localparam int VAL_W    = 32;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_DATUM = 1'b1;
    localparam logic [1:0] ROW_LOGW  = 2'd0;
    localparam logic [1:0] ROW_MEAN  = 2'd1;
    localparam logic [1:0] ROW_VAR   = 2'd2;

    // log2(e) and ln(2) in Q.30.
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    // 64.0 in Q.24 minus (LOG2E_Q30 + 1) / 2, folds the exponent offset back out.
    localparam logic [31:0] T_BIAS    = 32'd299200821;
    localparam logic [3:0]  TAYLOR_ORDER = 4'd12;

    typedef struct packed {
        logic              is_datum;
        logic [1:0]        row;
        logic [COMP_W-1:0] comp;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic        start;
        logic        long_mode;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

### rtl/mcc_front.sv
// Input side: accepts requests, drops meaningless loads, queues the rest.
module mcc_front
    import mcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [1:0]        s_row,
    input  logic [COMP_W-1:0] s_comp,
    input  logic [VAL_W-1:0]  s_coef,
    input  logic [VAL_W-1:0]  s_datum,
    output logic              q_valid,
    input  logic              q_ready,
    output item_t             q_item
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              keep, push, pop;
    item_t             new_item;

    assign s_ready = (cnt_reg < (QPTR_W+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    // Loads to a missing row or component are taken and forgotten.
    assign keep = (s_cmd == CMD_DATUM) ||
                  ((s_row != 2'd3) && (s_comp < COMP_W'(NUM_COMP)));
    assign push = s_valid && s_ready && keep;
    assign pop  = q_valid && q_ready;

    always_comb begin
        new_item.is_datum = s_cmd;
        new_item.row      = s_row;
        new_item.comp     = s_comp;
        new_item.value    = (s_cmd == CMD_DATUM) ? s_datum : s_coef;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/mcc_div.sv
// Restoring divider, one quotient bit per cycle, 64 or 32 steps.
module mcc_div
    import mcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  div_req_t    req,
    output logic        done,
    output logic [63:0] quotient
);

    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] shifted;
    logic        ge;

    assign shifted  = {rem_reg[31:0], quo_reg[63]};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.long_mode ? 7'd64 : 7'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/mcc_back.sv
// Execution side: component table, kernel sequencer and result register.
module mcc_back
    import mcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COMP_W-1:0] m_index,
    output logic [VAL_W-1:0]  m_cum,
    output logic              m_last,
    output logic              m_sat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_QDIV, ST_QWAIT, ST_MULT_T, ST_SPLIT,
        ST_MULT_Y, ST_Y, ST_TMUL, ST_TDIV, ST_TWAIT, ST_SCALE, ST_EMIT
    } state_t;

    logic [VAL_W-1:0] lw_mem  [NUM_COMP];
    logic [VAL_W-1:0] mu_mem  [NUM_COMP];
    logic [VAL_W-1:0] var_mem [NUM_COMP];

    state_t           state_reg;
    logic [COMP_W-1:0] comp_reg;
    logic [VAL_W-1:0] x_reg, lw_reg, var_reg;
    logic [63:0]      prod_reg;
    logic [29:0]      ep_reg;
    logic [7:0]       n_reg;
    logic [23:0]      f_reg;
    logic [29:0]      y_reg;
    logic [30:0]      term_reg;
    logic [31:0]      tsum_reg;
    logic [3:0]       k_reg;
    logic [64:0]      rprod_reg;
    logic [31:0]      kterm_reg;
    logic [31:0]      sum_reg;
    logic             sat_reg;
    logic             m_valid_reg, m_last_reg, m_sat_reg;
    logic [COMP_W-1:0] m_index_reg;
    logic [VAL_W-1:0] m_cum_reg;

    div_req_t         dreq;
    logic             div_done;
    logic [63:0]      div_q;

    logic [32:0]      d;
    logic [31:0]      mag;
    logic [41:0]      e;
    logic [31:0]      tu;
    logic [7:0]       sh, rsh;
    logic [33:0]      val;
    logic [32:0]      new_sum;
    logic             out_free;
    logic [34:0]      recip;

    mcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_index  = m_index_reg;
    assign m_cum    = m_cum_reg;
    assign m_last   = m_last_reg;
    assign m_sat    = m_sat_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        d   = {x_reg[31], x_reg} - {mu_mem[comp_reg][31], mu_mem[comp_reg]};
        mag = d[32] ? 32'(-d) : d[31:0];
        e   = {{10{lw_reg[31]}}, lw_reg} - {1'b0, div_q[40:0]};
        tu  = 32'((prod_reg[60:0] + 61'(1 << 29)) >> 30) + T_BIAS;
        sh  = n_reg - 8'd6;
        rsh = 8'd0 - sh;
        if (!sh[7]) begin
            val = {2'b00, tsum_reg} << sh[1:0];
        end else if (rsh >= 8'd32) begin
            val = '0;
        end else begin
            val = {2'b00, tsum_reg >> rsh[4:0]};
        end
        new_sum = {1'b0, sum_reg} + {1'b0, kterm_reg};
    end

    // ceil(2^34 / k): the product with a series numerator below 2^30, shifted
    // down by 34, is exactly the floor of the division by k.
    always_comb begin
        case (k_reg)
            4'd1:    recip = 35'd17179869184;
            4'd2:    recip = 35'd8589934592;
            4'd3:    recip = 35'd5726623062;
            4'd4:    recip = 35'd4294967296;
            4'd5:    recip = 35'd3435973837;
            4'd6:    recip = 35'd2863311531;
            4'd7:    recip = 35'd2454267027;
            4'd8:    recip = 35'd2147483648;
            4'd9:    recip = 35'd1908874354;
            4'd10:   recip = 35'd1717986919;
            4'd11:   recip = 35'd1561806290;
            4'd12:   recip = 35'd1431655766;
            default: recip = '0;
        endcase
    end

    always_comb begin
        dreq.start     = 1'b0;
        dreq.long_mode = 1'b1;
        dreq.dividend  = prod_reg;
        dreq.divisor   = var_reg;
        case (state_reg)
            ST_QDIV: begin
                dreq.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid && !q_item.is_datum) begin
            case (q_item.row)
                ROW_LOGW: lw_mem[q_item.comp]  <= q_item.value;
                ROW_MEAN: mu_mem[q_item.comp]  <= q_item.value;
                ROW_VAR:  var_mem[q_item.comp] <= q_item.value;
                default: begin
                end
            endcase
        end
    end

    // Datapath registers of the kernel sequence.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg    <= q_item.value;
                comp_reg <= '0;
                sum_reg  <= '0;
            end
            ST_FETCH: begin
                lw_reg    <= lw_mem[comp_reg];
                var_reg   <= var_mem[comp_reg];
                prod_reg  <= 64'(mag) * 64'(mag);
                kterm_reg <= '0;
            end
            ST_QWAIT: begin
                ep_reg <= 30'(e + 42'(32 << 24));
                if (div_done && (div_q[63:40] == '0) && !e[41] && (e > 42'(6 << 24))) begin
                    kterm_reg <= '1;
                end
            end
            ST_MULT_T: prod_reg <= 64'(ep_reg) * 64'(LOG2E_Q30);
            ST_SPLIT: begin
                n_reg <= tu[31:24] - 8'd64;
                f_reg <= tu[23:0];
            end
            ST_MULT_Y: prod_reg <= 64'(f_reg) * 64'(LN2_Q30);
            ST_Y: begin
                y_reg    <= prod_reg[53:24];
                term_reg <= 31'(1 << 30);
                tsum_reg <= 32'(1 << 30);
                k_reg    <= 4'd1;
            end
            ST_TMUL: prod_reg <= 64'(term_reg) * 64'(y_reg);
            ST_TDIV: rprod_reg <= 65'(prod_reg[59:30]) * 65'(recip);
            ST_TWAIT: begin
                term_reg <= rprod_reg[64:34];
                tsum_reg <= tsum_reg + {1'b0, rprod_reg[64:34]};
                k_reg    <= k_reg + 1'b1;
            end
            ST_SCALE: kterm_reg <= (val[33:32] != 2'b00) ? '1 : val[31:0];
            ST_EMIT: begin
                if (out_free) begin
                    sum_reg  <= new_sum[32] ? '1 : new_sum[31:0];
                    comp_reg <= comp_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state, the sticky flag and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_index_reg <= '0;
            m_cum_reg   <= '0;
            m_last_reg  <= 1'b0;
            m_sat_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_item.is_datum) begin
                        sat_reg   <= 1'b0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // A variance at or below zero gives a zero term and flags it.
                    if (var_mem[comp_reg][31] || (var_mem[comp_reg] == '0)) begin
                        sat_reg   <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_QDIV;
                    end
                end
                ST_QDIV: state_reg <= ST_QWAIT;
                ST_QWAIT: begin
                    if (div_done) begin
                        if (div_q[63:40] != '0) begin
                            state_reg <= ST_EMIT;
                        end else if (!e[41] && (e > 42'(6 << 24))) begin
                            sat_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else if (e[41] && (e < (42'd0 - 42'(32 << 24)))) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_MULT_T;
                        end
                    end
                end
                ST_MULT_T: state_reg <= ST_SPLIT;
                ST_SPLIT:  state_reg <= ST_MULT_Y;
                ST_MULT_Y: state_reg <= ST_Y;
                ST_Y:      state_reg <= ST_TMUL;
                ST_TMUL:   state_reg <= ST_TDIV;
                ST_TDIV:   state_reg <= ST_TWAIT;
                ST_TWAIT: begin
                    state_reg <= (k_reg == TAYLOR_ORDER) ? ST_SCALE : ST_TMUL;
                end
                ST_SCALE: begin
                    if (val[33:32] != 2'b00) begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_index_reg <= comp_reg;
                        m_cum_reg   <= new_sum[32] ? '1 : new_sum[31:0];
                        m_last_reg  <= (comp_reg == COMP_W'(NUM_COMP - 1));
                        m_sat_reg   <= sat_reg || new_sum[32];
                        if (new_sum[32]) begin
                            sat_reg <= 1'b1;
                        end
                        state_reg <= (comp_reg == COMP_W'(NUM_COMP - 1)) ? ST_IDLE : ST_FETCH;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/mixture_component_cdf.sv
// Top level of the mixture component CDF block.
//
// The block holds a table of ten mixture components (log weight, mean and
// variance, signed Q8.24). Each input request is either a load, which writes
// one table word and produces no result, or a datum, which produces ten
// results on the output channel. Result r carries the running sum over
// components 0 to r of exp(logw - (x - mean)^2 / variance) in unsigned Q8.24,
// with tlast on the tenth result and tuser set once any term or sum clipped or a variance was nonpositive.
// Loads to a table row or component that does not exist are taken and dropped.
// Requests enter a two-entry queue, so the input accepts while the kernel
// sequencer is busy or a finished result waits at the output.
// Each component runs a 64-step bit-serial division of the squared distance
// by the variance, then sums a series of twelve terms. A nonpositive variance
// skips both and yields a zero term; an out-of-range exponent skips the series.
// Reset clears the queue, the sequencer and the output valid; table contents
// are kept and must be written before a datum uses them. When the receiver
// holds tready low the result register holds, the sequencer waits on it,
// and the queue fills and then drops s_axis_tready.
module mixture_component_cdf
    import mcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from 0: component[3:0], coef_value[35:4], datum[67:36], zero pad.
    input  logic [71:0] s_axis_tdata,
    // Bits from 0: cmd[0], table_row[2:1].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from 0: component_index[3:0], cumulative[35:4], zero pad.
    output logic [39:0] m_axis_tdata,
    // Bits from 0: saturated[0].
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic              q_valid, q_ready;
    item_t             q_item;
    logic [COMP_W-1:0] m_index;
    logic [VAL_W-1:0]  m_cum;
    logic              m_sat;

    mcc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_cmd   (s_axis_tuser[0]),
        .s_row   (s_axis_tuser[2:1]),
        .s_comp  (s_axis_tdata[3:0]),
        .s_coef  (s_axis_tdata[35:4]),
        .s_datum (s_axis_tdata[67:36]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    mcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_index (m_index),
        .m_cum   (m_cum),
        .m_last  (m_axis_tlast),
        .m_sat   (m_sat)
    );

    assign m_axis_tdata = {4'd0, m_cum, m_index};
    assign m_axis_tuser = m_sat;

    // The last result of a datum always belongs to the final component.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == COMP_W'(NUM_COMP - 1)))
        else $error("tlast on a component other than the final one");

    // A result never names a component outside the table.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[3:0] < COMP_W'(NUM_COMP)))
        else $error("result component index out of range");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
